>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define GDR_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define GDR_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define GDR_ASSERT_NEXT_RST(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/core/gdr_pkg.sv
package gdr_pkg;

    // Command codes carried in tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_WIDTH   = 3'd6;

    // Datapath widths.
    localparam int DIV_W   = 31;
    localparam int CAMX_W  = 29;
    localparam int PROD_W  = 16 + CAMX_W;
    localparam int RAY_W   = 32;
    localparam int DELTA_W = 49;
    localparam int FRAC_W  = 9;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 56;

    localparam logic [DIV_W-1:0]   DELTA_NUM = 31'h4000_0000;
    localparam logic [DELTA_W-1:0] DELTA_INF = 49'h1_0000_0000_0000;

    typedef struct packed {
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic [12:0]        width;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [11:0]       col;
        logic [5:0]        cx;
        logic [5:0]        cy;
        logic signed [7:0] data;
        logic              wr_ok;
    } t_item;

    typedef struct packed {
        logic              valid;
        t_item             item;
    } t_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic [5:0]        hy;
        logic [5:0]        hx;
        logic signed [7:0] hcell;
        logic [15:0]       wdist;
        logic              side;
        logic              hit;
        logic [11:0]       col;
    } t_result;

endpackage

>>> rtl/core/gdr_div.sv
module gdr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gdr_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [gdr_pkg::DIV_W-1:0] o_quo
);
    import gdr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W:0]   r_rem;
    logic [DIV_W:0]   n_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] n_quo;
    logic [DIV_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] rem_sub;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        rem_sh  = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        rem_sub = {1'b0, rem_sh} - {2'b00, r_den};
        if (!rem_sub[DIV_W+1]) begin
            n_rem = rem_sub[DIV_W:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh;
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/core/gdr_front.sv
module gdr_front #(
    parameter int MAP_SIZE = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [gdr_pkg::IN_W-1:0] i_s_tdata,
    input  logic                     i_s_tuser,
    input  gdr_pkg::t_back_stat      i_stat,
    output gdr_pkg::t_head           o_head
);
    import gdr_pkg::*;

    localparam int DEPTH = 2;

    t_item      r_q [DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      in_item;
    logic       push;
    logic       pop;

    // Unpack the request and mark writes that land inside the map.
    always_comb begin
        in_item.cmd   = i_s_tuser;
        in_item.col   = i_s_tdata[11:0];
        in_item.cx    = i_s_tdata[17:12];
        in_item.cy    = i_s_tdata[23:18];
        in_item.data  = i_s_tdata[31:24];
        in_item.wr_ok = (9'(i_s_tdata[17:12]) < 9'(MAP_SIZE))
                     && (9'(i_s_tdata[23:18]) < 9'(MAP_SIZE));
    end

    assign o_s_tready = (r_cnt != 2'(DEPTH)) && !i_stat.clearing;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_stat.pop && (r_cnt != 2'd0);

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

endmodule

>>> rtl/core/gdr_back.sv
module gdr_back #(
    parameter int MAP_SIZE = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gdr_pkg::t_head            i_head,
    output gdr_pkg::t_back_stat       o_stat,
    input  gdr_pkg::t_cfg             i_cfg,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [gdr_pkg::OUT_W-1:0] o_m_tdata
);
    import gdr_pkg::*;

    localparam int DEPTH  = MAP_SIZE * MAP_SIZE;
    localparam int AW     = $clog2(DEPTH);
    localparam int LIMIT  = 4 * MAP_SIZE + 8;
    localparam int CNT_W  = $clog2(LIMIT + 1);
    localparam int SD_W   = DELTA_W + CNT_W;
    localparam int SP_W   = FRAC_W + DELTA_W;
    localparam int MC_W   = 10;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CAMX  = 4'd2;
    localparam logic [3:0] ST_MULX  = 4'd3;
    localparam logic [3:0] ST_ADDX  = 4'd4;
    localparam logic [3:0] ST_MULY  = 4'd5;
    localparam logic [3:0] ST_ADDY  = 4'd6;
    localparam logic [3:0] ST_DIVX  = 4'd7;
    localparam logic [3:0] ST_WDX   = 4'd8;
    localparam logic [3:0] ST_DIVY  = 4'd9;
    localparam logic [3:0] ST_WDY   = 4'd10;
    localparam logic [3:0] ST_SSX   = 4'd11;
    localparam logic [3:0] ST_SSY   = 4'd12;
    localparam logic [3:0] ST_STEP  = 4'd13;
    localparam logic [3:0] ST_TEST  = 4'd14;
    localparam logic [3:0] ST_FIN   = 4'd15;

    logic [3:0]               r_state;
    logic [AW-1:0]            r_clr_addr;
    logic [11:0]              r_col;
    logic                     r_neg;
    logic signed [CAMX_W-1:0] r_camx;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RAY_W-1:0]  r_rx;
    logic signed [RAY_W-1:0]  r_ry;
    logic [DELTA_W-1:0]       r_dx;
    logic [DELTA_W-1:0]       r_dy;
    logic [SP_W-1:0]          r_sprod;
    logic [SD_W-1:0]          r_sdx;
    logic [SD_W-1:0]          r_sdy;
    logic signed [MC_W-1:0]   r_mx;
    logic signed [MC_W-1:0]   r_my;
    logic                     r_side;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_oob;
    logic signed [7:0]        r_rd_data;
    t_result                  r_res;
    t_result                  r_out;
    logic                     r_out_valid;
    logic signed [7:0]        mem [DEPTH];

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [7:0]        mem_wdata;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [12:0]              w_eff;
    logic signed [14:0]       cam_num;
    logic [13:0]              cam_mag;
    t_div_req                 div_req;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [RAY_W-1:0]  ray_sum;
    logic signed [RAY_W-1:0]  cur_ray;
    logic signed [15:0]       cur_dir;
    logic signed [15:0]       cur_plane;
    logic [RAY_W-1:0]         rx_mag;
    logic [RAY_W-1:0]         ry_mag;
    logic [FRAC_W-1:0]        frac_x;
    logic [FRAC_W-1:0]        frac_y;
    logic [FRAC_W-1:0]        ss_frac;
    logic [DELTA_W-1:0]       ss_delta;
    logic [SP_W-1:0]          ss_prod;
    logic [SD_W-1:0]          sdy_cur;
    logic                     take_x;
    logic signed [MC_W-1:0]   nx_mx;
    logic signed [MC_W-1:0]   nx_my;
    logic                     nx_oob;
    logic [SD_W-1:0]          dist_raw;
    logic [SD_W-1:0]          dist_sh;
    logic                     out_free;

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Camera-space numerator: (2*column - width) scaled by 2^14 before division.
    always_comb begin
        w_eff   = (i_cfg.width == 13'd0) ? 13'd1 : i_cfg.width;
        cam_num = $signed({2'b00, i_head.item.col, 1'b0}) - $signed({2'b00, w_eff});
        cam_mag = cam_num[14] ? 14'(-cam_num) : cam_num[13:0];
    end

    // Ray components: one multiply, then truncation toward zero.
    always_comb begin
        prod_adj  = r_prod[PROD_W-1] ? (r_prod + PROD_W'(16383)) : r_prod;
        cur_dir   = (r_state == ST_ADDX) ? i_cfg.dir_x : i_cfg.dir_y;
        cur_plane = (r_state == ST_MULX) ? i_cfg.plane_x : i_cfg.plane_y;
        ray_sum   = RAY_W'(cur_dir) + RAY_W'(prod_adj >>> 14);
        cur_ray   = r_rx;
        rx_mag    = r_rx[RAY_W-1] ? RAY_W'(-r_rx) : r_rx;
        ry_mag    = r_ry[RAY_W-1] ? RAY_W'(-r_ry) : r_ry;
        frac_x    = r_rx[RAY_W-1] ? {1'b0, i_cfg.pos_x[7:0]}
                                  : (9'd256 - {1'b0, i_cfg.pos_x[7:0]});
        frac_y    = r_ry[RAY_W-1] ? {1'b0, i_cfg.pos_y[7:0]}
                                  : (9'd256 - {1'b0, i_cfg.pos_y[7:0]});
    end

    // Start distance: the infinity stand-in is a plain shift, any real
    // reciprocal fits in the divider width and takes a narrow multiply.
    always_comb begin
        ss_frac  = (r_state == ST_SSX) ? frac_x : frac_y;
        ss_delta = (r_state == ST_SSX) ? r_dx : r_dy;
        if (ss_delta[DELTA_W-1]) begin
            ss_prod = SP_W'({ss_frac, {(DELTA_W-1){1'b0}}});
        end else begin
            ss_prod = SP_W'(ss_frac * ss_delta[DIV_W-1:0]);
        end
    end

    // Divider requests: camera offset, then the two reciprocals.
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = DELTA_NUM;
        div_req.den   = rx_mag[DIV_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                div_req.start = i_head.valid && (i_head.item.cmd == CMD_CAST);
                div_req.num   = {3'b000, cam_mag, 14'd0};
                div_req.den   = DIV_W'(w_eff);
            end
            ST_DIVX: begin
                div_req.start = (cur_ray != '0);
            end
            ST_DIVY: begin
                div_req.start = (r_ry != '0);
                div_req.den   = ry_mag[DIV_W-1:0];
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // One DDA step: advance on the smaller side distance, y on a tie.
    // On the first step the y start distance still sits in the product register.
    always_comb begin
        sdy_cur = (r_cnt == '0) ? SD_W'(r_sprod >> 8) : r_sdy;
        take_x  = (r_sdx < sdy_cur);
        nx_mx   = r_mx;
        nx_my   = r_my;
        if (take_x) begin
            nx_mx = r_rx[RAY_W-1] ? (r_mx - 1'b1) : (r_mx + 1'b1);
        end else begin
            nx_my = r_ry[RAY_W-1] ? (r_my - 1'b1) : (r_my + 1'b1);
        end
        nx_oob = nx_mx[MC_W-1] || nx_my[MC_W-1]
              || (nx_mx >= MC_W'(MAP_SIZE)) || (nx_my >= MC_W'(MAP_SIZE));
        rd_en   = (r_state == ST_STEP);
        rd_addr = AW'(int'(nx_mx) * MAP_SIZE + int'(nx_my));
    end

    // Perpendicular distance with saturation.
    always_comb begin
        dist_raw = r_side ? (r_sdy - SD_W'(r_dy)) : (r_sdx - SD_W'(r_dx));
        dist_sh  = dist_raw >> 8;
    end

    // Map write port: clearing pass or a write request.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if ((r_state == ST_IDLE) && i_head.valid
                     && (i_head.item.cmd == CMD_WRITE) && i_head.item.wr_ok) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(int'(i_head.item.cx) * MAP_SIZE + int'(i_head.item.cy));
            mem_wdata = i_head.item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= (i_head.item.cmd == CMD_WRITE) ? ST_FIN : ST_CAMX;
                    end
                end
                ST_CAMX: begin
                    if (div_done) begin
                        r_state <= ST_MULX;
                    end
                end
                ST_MULX: r_state <= ST_ADDX;
                ST_ADDX: r_state <= ST_MULY;
                ST_MULY: r_state <= ST_ADDY;
                ST_ADDY: r_state <= ST_DIVX;
                ST_DIVX: r_state <= (cur_ray == '0) ? ST_DIVY : ST_WDX;
                ST_WDX: begin
                    if (div_done) begin
                        r_state <= ST_DIVY;
                    end
                end
                ST_DIVY: r_state <= (r_ry == '0) ? ST_SSX : ST_WDY;
                ST_WDY: begin
                    if (div_done) begin
                        r_state <= ST_SSX;
                    end
                end
                ST_SSX: r_state <= ST_SSY;
                ST_SSY: r_state <= ST_STEP;
                ST_STEP: r_state <= ST_TEST;
                ST_TEST: begin
                    if (r_oob || (r_rd_data != 8'sd0) || (r_cnt == CNT_W'(LIMIT))) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_STEP;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_col <= i_head.item.col;
                r_neg <= cam_num[14];
                r_res <= '0;
            end
            ST_CAMX: begin
                r_camx <= r_neg ? -$signed(div_quo[CAMX_W-1:0])
                                : $signed(div_quo[CAMX_W-1:0]);
            end
            ST_MULX, ST_MULY: begin
                r_prod <= PROD_W'(cur_plane * r_camx);
            end
            ST_ADDX: r_rx <= ray_sum;
            ST_ADDY: r_ry <= ray_sum;
            ST_DIVX: begin
                if (cur_ray == '0) begin
                    r_dx <= DELTA_INF;
                end
            end
            ST_WDX: r_dx <= DELTA_W'(div_quo);
            ST_DIVY: begin
                if (r_ry == '0) begin
                    r_dy <= DELTA_INF;
                end
            end
            ST_WDY: r_dy <= DELTA_W'(div_quo);
            ST_SSX: begin
                r_sprod <= ss_prod;
            end
            ST_SSY: begin
                r_sdx   <= SD_W'(r_sprod >> 8);
                r_sprod <= ss_prod;
                r_mx    <= MC_W'(i_cfg.pos_x[15:8]);
                r_my    <= MC_W'(i_cfg.pos_y[15:8]);
                r_cnt   <= '0;
            end
            ST_STEP: begin
                if (take_x) begin
                    r_sdx  <= r_sdx + SD_W'(r_dx);
                    r_sdy  <= sdy_cur;
                    r_side <= 1'b0;
                end else begin
                    r_sdy  <= sdy_cur + SD_W'(r_dy);
                    r_side <= 1'b1;
                end
                r_mx  <= nx_mx;
                r_my  <= nx_my;
                r_cnt <= r_cnt + 1'b1;
                r_oob <= nx_oob;
            end
            ST_TEST: begin
                r_res.col <= r_col;
                if (!r_oob && (r_rd_data != 8'sd0)) begin
                    r_res.hit   <= 1'b1;
                    r_res.side  <= r_side;
                    r_res.wdist <= (|dist_sh[SD_W-1:16]) ? 16'hFFFF : dist_sh[15:0];
                    r_res.hcell <= r_rd_data;
                    r_res.hx    <= r_mx[5:0];
                    r_res.hy    <= r_my[5:0];
                end else begin
                    r_res.hit   <= 1'b0;
                    r_res.side  <= 1'b0;
                    r_res.wdist <= '0;
                    r_res.hcell <= '0;
                    r_res.hx    <= '0;
                    r_res.hy    <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_stat.pop      = (r_state == ST_IDLE);
    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = OUT_W'(r_out);

endmodule

>>> rtl/core/grid_dda_ray_caster.sv
// Grid ray caster with a MAP_SIZE x MAP_SIZE map of signed 8-bit cells.
// Input stream: tuser selects the request (0 writes a cell, 1 casts a column).
// Every request gives exactly one result on the output stream, in order;
// a write gives an all-zero result, a cast gives hit, side, Q8.8 distance
// and the cell reached.
// Configuration registers are loaded through the write port; the user
// must load them only while idle, as the block does not enforce it. A
// cast runs up to three passes of the shared restoring divider (camera
// offset, x and y reciprocals, a reciprocal skipped for a zero ray
// component), multiply and setup steps, and grid steps that each wait
// for the registered map read.
// Requests pass through a two-entry queue and the sequencer, so while a
// result waits in the output register for tready, three more can enter.
// After reset all MAP_SIZE*MAP_SIZE cells (4096 by default) of the map
// are cleared, one per cycle; input tready stays low during that pass.
// Configuration registers return to their default view at reset.
module grid_dda_ray_caster #(
    parameter int MAP_SIZE = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // tdata: column[11:0], cell_x[17:12], cell_y[23:18], cell_data[31:24]
    input  logic [gdr_pkg::IN_W-1:0]  i_s_axis_tdata,
    // tuser: command[0]
    input  logic                      i_s_axis_tuser,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata: column_out[11:0], hit[12], side[13], wall_distance[29:14],
    //        hit_cell[37:30], hit_x[43:38], hit_y[49:44], zero fill above
    output logic [gdr_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [15:0]               i_cfg_data
);
    import gdr_pkg::*;

    t_cfg       r_cfg;
    t_head      head;
    t_back_stat stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x   <= 16'd8192;
            r_cfg.pos_y   <= 16'd8192;
            r_cfg.dir_x   <= -16'sd16384;
            r_cfg.dir_y   <= 16'sd0;
            r_cfg.plane_x <= 16'sd0;
            r_cfg.plane_y <= 16'sd10813;
            r_cfg.width   <= 13'd320;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POS_X:   r_cfg.pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_cfg.pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_cfg.dir_x   <= i_cfg_data;
                CFG_DIR_Y:   r_cfg.dir_y   <= i_cfg_data;
                CFG_PLANE_X: r_cfg.plane_x <= i_cfg_data;
                CFG_PLANE_Y: r_cfg.plane_y <= i_cfg_data;
                CFG_WIDTH:   r_cfg.width   <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    gdr_front #(
        .MAP_SIZE (MAP_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_stat     (stat),
        .o_head     (head)
    );

    gdr_back #(
        .MAP_SIZE (MAP_SIZE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_stat     (stat),
        .i_cfg      (r_cfg),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

>>> rtl/core/gdr_checker.sv
`include "assert_macros.svh"

module gdr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tready,
    input logic                      i_m_tvalid,
    input logic                      i_m_tready,
    input logic [gdr_pkg::OUT_W-1:0] i_m_tdata
);

    // A pending result is not withdrawn.
    `GDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)

    // A result without a hit carries no hit details.
    `GDR_ASSERT_NOW(a_miss_clean, i_clk, i_rst_n, i_m_tvalid && !i_m_tdata[12], i_m_tdata[49:13] == '0)

    // Reset leaves no result pending.
    `GDR_ASSERT_NEXT_RST(a_rst_out, i_clk, !i_rst_n, !i_m_tvalid)

    // Reset holds off requests, since the map is cleared after reset.
    `GDR_ASSERT_NEXT_RST(a_rst_busy, i_clk, !i_rst_n, !i_s_tready)

endmodule

bind grid_dda_ray_caster gdr_checker u_gdr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
